@@ design/ole_pkg.sv @@
`default_nettype none

package ole_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 64;
    localparam int PORT_KEY_W   = 64;
    localparam int POS_W        = 7;
    localparam int CAP_W        = 7;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_FIND_NAME = 3'd3,
        OP_FIND_ID   = 3'd4,
        OP_COUNT     = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic [POS_W-1:0]        found_position;
        logic [PORT_KEY_W-1:0]   found_id;
        logic [PORT_KEY_W-1:0]   found_name;
        logic [POS_W-1:0]        entry_count;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ctrl_stat;

endpackage

`default_nettype wire

@@ design/ole_store.sv @@
`default_nettype none

module ole_store
    import ole_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = 2 * KEY_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/ole_ctrl.sv @@
`default_nettype none

module ole_ctrl
    import ole_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [OP_W-1:0]          i_op,
    input  wire logic [POS_W-1:0]         i_pos,
    input  wire logic [KEY_BITS-1:0]      i_id,
    input  wire logic [KEY_BITS-1:0]      i_name,
    input  wire logic [CAP_W-1:0]         i_cap,
    input  wire logic                     i_take,
    output t_ctrl_stat                    o_stat,
    output t_result                       o_res,
    output logic                          o_mem_we,
    output logic [$clog2(DEPTH)-1:0]      o_mem_waddr,
    output logic [2*KEY_BITS-1:0]         o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(DEPTH)-1:0]      o_mem_raddr,
    input  wire logic [2*KEY_BITS-1:0]    i_mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SHIFT_UP = 5'b00010,
        S_SHIFT_DN = 5'b00100,
        S_SEARCH   = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [KEY_BITS-1:0] r_id, n_id;
    logic [KEY_BITS-1:0] r_name, n_name;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_left, n_left;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    t_status             r_status, n_status;
    logic [POS_W-1:0]    r_fpos, n_fpos;
    logic [KEY_BITS-1:0] r_fid, n_fid;
    logic [KEY_BITS-1:0] r_fname, n_fname;

    logic [XW-1:0]       cnt_x, pos_x, cap_x, depth_x, cap_eff;
    logic                full;
    logic [KEY_BITS-1:0] rd_id, rd_name;
    logic                match;

    assign cnt_x   = XW'(r_count);
    assign pos_x   = XW'(i_pos);
    assign cap_x   = XW'(i_cap);
    assign depth_x = XW'(DEPTH);
    assign cap_eff = (cap_x > depth_x) ? depth_x : cap_x;
    assign full    = (cnt_x >= cap_eff);

    assign rd_id   = i_mem_rdata[2*KEY_BITS-1:KEY_BITS];
    assign rd_name = i_mem_rdata[KEY_BITS-1:0];
    // one key compare for both search kinds: name or id, as the op selects
    assign match   = (r_op == OP_FIND_NAME) ? (rd_name == r_name) : (rd_id == r_id);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_id        = r_id;
        n_name      = r_name;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_status    = r_status;
        n_fpos      = r_fpos;
        n_fid       = r_fid;
        n_fname     = r_fname;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pend_addr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (i_start) begin
                    n_op     = t_op'(i_op);
                    n_pos    = i_pos;
                    n_id     = i_id;
                    n_name   = i_name;
                    n_status = ST_OK;
                    n_fpos   = '0;
                    n_fid    = '0;
                    n_fname  = '0;
                    n_state  = S_DONE;
                    unique case (t_op'(i_op))
                        OP_APPEND: begin
                            if (full) begin
                                n_status = ST_REJECT;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(cnt_x);
                                o_mem_wdata = {i_id, i_name};
                                n_count     = r_count + CW'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (pos_x == '0 || pos_x > cnt_x + XW'(1) || full) begin
                                n_status = ST_REJECT;
                            end else begin
                                // walk from the tail down to the insertion point
                                n_ptr   = AW'(cnt_x - XW'(1));
                                n_left  = CW'(cnt_x - pos_x + XW'(1));
                                n_state = S_SHIFT_UP;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_REJECT;
                            end else begin
                                n_ptr   = AW'(pos_x);
                                n_left  = CW'(cnt_x - pos_x);
                                n_state = S_SHIFT_DN;
                            end
                        end
                        OP_FIND_NAME, OP_FIND_ID: begin
                            n_ptr   = '0;
                            n_left  = r_count;
                            n_state = S_SEARCH;
                        end
                        OP_COUNT: begin
                            n_status = ST_OK;
                        end
                        default: begin
                            n_status = ST_REJECT;
                        end
                    endcase
                end
            end

            S_SHIFT_UP: begin
                // entry read last cycle lands one slot higher
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pend_addr + AW'(1);
                    o_mem_wdata = i_mem_rdata;
                end else if (r_left == '0) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(XW'(r_pos) - XW'(1));
                    o_mem_wdata = {r_id, r_name};
                    n_count     = r_count + CW'(1);
                    n_state     = S_DONE;
                end
                if (r_left != '0) begin
                    o_mem_re = 1'b1;
                    n_ptr    = r_ptr - AW'(1);
                    n_left   = r_left - CW'(1);
                end
                n_pend      = (r_left != '0);
                n_pend_addr = r_ptr;
            end

            S_SHIFT_DN: begin
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pend_addr - AW'(1);
                    o_mem_wdata = i_mem_rdata;
                end else if (r_left == '0) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
                if (r_left != '0) begin
                    o_mem_re = 1'b1;
                    n_ptr    = r_ptr + AW'(1);
                    n_left   = r_left - CW'(1);
                end
                n_pend      = (r_left != '0);
                n_pend_addr = r_ptr;
            end

            S_SEARCH: begin
                if (r_pend && match) begin
                    n_status = ST_OK;
                    n_fpos   = POS_W'(XW'(r_pend_addr) + XW'(1));
                    n_fid    = rd_id;
                    n_fname  = rd_name;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                end else if (!r_pend && r_left == '0) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    if (r_left != '0) begin
                        o_mem_re = 1'b1;
                        n_ptr    = r_ptr + AW'(1);
                        n_left   = r_left - CW'(1);
                    end
                    n_pend      = (r_left != '0);
                    n_pend_addr = r_ptr;
                end
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_id        <= n_id;
        r_name      <= n_name;
        r_ptr       <= n_ptr;
        r_left      <= n_left;
        r_pend_addr <= n_pend_addr;
        r_status    <= n_status;
        r_fpos      <= n_fpos;
        r_fid       <= n_fid;
        r_fname     <= n_fname;
    end

    assign o_stat.busy          = (r_state != S_IDLE);
    assign o_stat.done          = (r_state == S_DONE);
    assign o_res.status         = r_status;
    assign o_res.found_position = r_fpos;
    assign o_res.found_id       = PORT_KEY_W'(r_fid);
    assign o_res.found_name     = PORT_KEY_W'(r_fname);
    assign o_res.entry_count    = POS_W'(cnt_x);

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |-> !o_mem_we)
        else $error("store written while idle");

    a_done_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_count == $past(r_count)))
        else $error("count moved while result pending");

    a_no_addr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("shift read and write hit the same entry");

    a_count_only_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state != S_IDLE || i_start))
        else $error("count changed with no transaction in progress");

endmodule

`default_nettype wire

@@ design/ordered_list_engine.sv @@
`default_nettype none

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------------------
// in       | i_in_valid   | o_in_stall   | i_op, i_position, i_id_key, i_name_key
// out      | o_out_valid  | i_out_stall  | o_status, o_found_position, o_found_id,
//          |              |              | o_found_name, o_entry_count
// cfg      | i_cfg_we     | none         | i_cfg_wdata (capacity in use)
//
// append, get count and rejected ops go from accept to the done state, then to the output register
// insert at p moves the entries from the tail down to p one slot up, remove at p moves
// the entries after p one slot down: one list entry moves per cycle through the
// record store, one read and one write port
// search scans from the head and stops at the first match, one compare per stored entry read
// o_in_stall is high from accept until the result is loaded into the output register
// reset clears the count and control state, store contents are undefined until written

module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [POS_W-1:0]      i_position,
    input  wire logic [PORT_KEY_W-1:0] i_id_key,
    input  wire logic [PORT_KEY_W-1:0] i_name_key,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [POS_W-1:0]           o_found_position,
    output logic [PORT_KEY_W-1:0]      o_found_id,
    output logic [PORT_KEY_W-1:0]      o_found_name,
    output logic [POS_W-1:0]           o_entry_count,
    input  wire logic                  i_cfg_we,
    input  wire logic [CAP_W-1:0]      i_cfg_wdata
);

    localparam int AW = $clog2(DEPTH);

    logic [CAP_W-1:0] r_cap;
    logic             r_out_valid, n_out_valid;
    t_result          r_out;

    t_ctrl_stat          ctrl_stat;
    t_result             ctrl_res;
    logic                start, take;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [2*KEY_BITS-1:0] mem_wdata, mem_rdata;

    assign o_in_stall = ctrl_stat.busy;
    assign start      = i_in_valid && !ctrl_stat.busy;
    // result leaves the sequencer when the output register is free or draining
    assign take       = ctrl_stat.done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= ctrl_res;
        end
    end

    ole_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_op),
        .i_pos       (i_position),
        .i_id        (i_id_key[KEY_BITS-1:0]),
        .i_name      (i_name_key[KEY_BITS-1:0]),
        .i_cap       (r_cap),
        .i_take      (take),
        .o_stat      (ctrl_stat),
        .o_res       (ctrl_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ole_store #(
        .DEPTH (DEPTH),
        .WIDTH (2 * KEY_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found_position;
    assign o_found_id       = r_out.found_id;
    assign o_found_name     = r_out.found_name;
    assign o_entry_count    = r_out.entry_count;

endmodule

`default_nettype wire

@@ tb/ordered_list_engine_test.sv @@
`default_nettype none

module ordered_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam logic [OP_W-1:0] OP_BAD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_7 = 3'd7;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 300;

    // tracks the list contents and the replies still owed by the engine
    class list_scoreboard;
        logic [PORT_KEY_W-1:0] ids [DEPTH_DEF];
        logic [PORT_KEY_W-1:0] names [DEPTH_DEF];
        int entries;
        int capacity;
        int peak;
        t_result awaited [$];
        int requests, replies, rejects, misses, mismatches;

        function new();
            entries = 0;
            capacity = int'(CAP_RESET);
            peak = 0;
            requests = 0;
            replies = 0;
            rejects = 0;
            misses = 0;
            mismatches = 0;
        endfunction

        function int room();
            return (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [PORT_KEY_W-1:0] idk, logic [PORT_KEY_W-1:0] namek);
            t_result r;
            int p;
            bit hit;
            r = '0;
            r.status = ST_OK;
            p = int'(pos);
            case (op)
                OP_APPEND: begin
                    if (entries < room()) begin
                        ids[entries] = idk;
                        names[entries] = namek;
                        entries++;
                    end else begin
                        r.status = ST_REJECT;
                    end
                end
                OP_INSERT: begin
                    if (p < 1 || p > entries + 1 || entries >= room()) begin
                        r.status = ST_REJECT;
                    end else begin
                        for (int j = entries; j >= p; j--) begin
                            ids[j] = ids[j-1];
                            names[j] = names[j-1];
                        end
                        ids[p-1] = idk;
                        names[p-1] = namek;
                        entries++;
                    end
                end
                OP_REMOVE: begin
                    if (p < 1 || p > entries) begin
                        r.status = ST_REJECT;
                    end else begin
                        for (int j = p - 1; j + 1 < entries; j++) begin
                            ids[j] = ids[j+1];
                            names[j] = names[j+1];
                        end
                        entries--;
                    end
                end
                OP_FIND_NAME, OP_FIND_ID: begin
                    r.status = ST_NOT_FOUND;
                    hit = 1'b0;
                    for (int j = 0; j < entries && !hit; j++) begin
                        if (op == OP_FIND_NAME ? names[j] == namek : ids[j] == idk) begin
                            hit = 1'b1;
                            r.status = ST_OK;
                            r.found_position = POS_W'(j + 1);
                            r.found_id = ids[j];
                            r.found_name = names[j];
                        end
                    end
                end
                OP_COUNT: ;
                default: r.status = ST_REJECT;
            endcase
            r.entry_count = POS_W'(entries);
            if (entries > peak)
                peak = entries;
            if (r.status == ST_REJECT)
                rejects++;
            if (r.status == ST_NOT_FOUND)
                misses++;
            requests++;
            awaited.push_back(r);
        endfunction

        function void flag(string field, logic [PORT_KEY_W-1:0] want, logic [PORT_KEY_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         field, replies, want, got);
        endfunction

        function void check_reply(t_result got);
            t_result want;
            replies++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing outstanding", replies);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.found_position !== want.found_position)
                flag("found_position", want.found_position, got.found_position);
            if (got.found_id !== want.found_id)
                flag("found_id", want.found_id, got.found_id);
            if (got.found_name !== want.found_name)
                flag("found_name", want.found_name, got.found_name);
            if (got.entry_count !== want.entry_count)
                flag("entry_count", want.entry_count, got.entry_count);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_op = OP_COUNT;
    logic [POS_W-1:0]      i_position = '0;
    logic [PORT_KEY_W-1:0] i_id_key = '0;
    logic [PORT_KEY_W-1:0] i_name_key = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [POS_W-1:0]      o_found_position;
    logic [PORT_KEY_W-1:0] o_found_id;
    logic [PORT_KEY_W-1:0] o_found_name;
    logic [POS_W-1:0]      o_entry_count;
    logic                  i_cfg_we = 1'b0;
    logic [CAP_W-1:0]      i_cfg_wdata = '0;

    list_scoreboard sb = new();
    logic [PORT_KEY_W-1:0] key_pool [8];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycles = 0;

    ordered_list_engine DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_position       (i_position),
        .i_id_key         (i_id_key),
        .i_name_key       (i_name_key),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_found_id       (o_found_id),
        .o_found_name     (o_found_name),
        .o_entry_count    (o_entry_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycles);
            $display("ordered_list_engine_test NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reply('{t_status'(o_status), o_found_position, o_found_id,
                             o_found_name, o_entry_count});
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [PORT_KEY_W-1:0] idk,
                             input logic [PORT_KEY_W-1:0] namek);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_position <= pos;
        i_id_key <= idk;
        i_name_key <= namek;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(op, pos, idk, namek);
        @(negedge i_clk);
    endtask

    task automatic wait_all_answered();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        wait_all_answered();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CAP_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.capacity = value;
    endtask

    function automatic logic [PORT_KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return key_pool[$urandom_range(7)];
        if (r < 9)
            return {$urandom, $urandom};
        return $urandom_range(1) ? '0 : '1;
    endfunction

    // grow: share of transactions forced to append or insert
    task automatic send_random(input int n, input int grow);
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic [PORT_KEY_W-1:0] idk, namek;
        int r, k;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < grow) begin
                op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
            end else begin
                r = $urandom_range(99);
                if (r < 18)      op = OP_APPEND;
                else if (r < 34) op = OP_INSERT;
                else if (r < 52) op = OP_REMOVE;
                else if (r < 68) op = OP_FIND_NAME;
                else if (r < 84) op = OP_FIND_ID;
                else if (r < 92) op = OP_COUNT;
                else             op = $urandom_range(1) ? OP_BAD_6 : OP_BAD_7;
            end
            if ($urandom_range(99) < 20)
                pos = POS_W'($urandom_range(127));
            else if (op == OP_INSERT)
                pos = POS_W'($urandom_range(sb.entries + 1, 1));
            else
                pos = POS_W'($urandom_range(sb.entries > 0 ? sb.entries : 1, 1));
            idk = pick_key();
            namek = pick_key();
            // mostly search for keys that are actually stored
            if (sb.entries > 0 && $urandom_range(99) < 60) begin
                k = $urandom_range(sb.entries - 1);
                if (op == OP_FIND_NAME)
                    namek = sb.names[k];
                else if (op == OP_FIND_ID)
                    idk = sb.ids[k];
            end
            send_item(op, pos, idk, namek);
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list, bad positions, edge keys, duplicates, bad ops
        send_item(OP_COUNT, 7'd0, '0, '0);
        send_item(OP_REMOVE, 7'd1, '0, '0);
        send_item(OP_FIND_NAME, 7'd0, '0, '0);
        send_item(OP_INSERT, 7'd0, key_pool[0], key_pool[1]);
        send_item(OP_INSERT, 7'd2, key_pool[0], key_pool[1]);
        send_item(OP_INSERT, 7'd1, '0, '1);
        send_item(OP_APPEND, 7'd0, '1, '0);
        send_item(OP_APPEND, 7'd0, key_pool[2], key_pool[3]);
        send_item(OP_INSERT, 7'd2, key_pool[4], key_pool[3]);
        send_item(OP_FIND_NAME, 7'd0, '0, key_pool[3]);
        send_item(OP_FIND_ID, 7'd0, '1, '0);
        send_item(OP_FIND_ID, 7'd0, '0, '1);
        send_item(OP_FIND_NAME, 7'd0, '0, key_pool[5]);
        send_item(OP_REMOVE, 7'd0, '0, '0);
        send_item(OP_REMOVE, 7'd5, '0, '0);
        send_item(OP_REMOVE, 7'd127, '1, '1);
        send_item(OP_INSERT, 7'd127, '1, '1);
        send_item(OP_BAD_6, 7'd1, '0, '0);
        send_item(OP_BAD_7, 7'd1, '1, '1);
        send_item(OP_REMOVE, 7'd4, '0, '0);
        send_item(OP_REMOVE, 7'd1, '0, '0);
        send_item(OP_INSERT, 7'd3, key_pool[6], key_pool[7]);

        // zero capacity: nothing may be added, removal still works
        write_capacity(0);
        send_item(OP_APPEND, 7'd0, key_pool[0], key_pool[0]);
        send_item(OP_INSERT, 7'd1, key_pool[0], key_pool[0]);
        send_item(OP_REMOVE, 7'd1, '0, '0);
        send_item(OP_COUNT, 7'd0, '0, '0);

        send_idle_pct = 35;
        recv_idle_pct = 57;
        write_capacity(12);
        send_random(270, 10);

        send_idle_pct = 57;
        recv_idle_pct = 35;
        // capacity likely below the current fill
        write_capacity(3);
        send_random(80, 0);
        // above the depth, so the list can be filled to the brim
        write_capacity(127);
        send_random(190, 45);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(64);
        send_random(100, 0);
        hold_req = 1;
        send_random(60, 0);
        wait_all_answered();
        send_random(100, 0);

        wait_all_answered();
        repeat (10) @(negedge i_clk);

        $display("covered %0d transactions at capacities 0, 3, 12, 64 and 127, peak fill %0d",
                 sb.requests, sb.peak);
        $display("%0d results checked: %0d rejected, %0d not found, %0d mismatches",
                 sb.replies, sb.rejects, sb.misses, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("ordered_list_engine_test OK");
        end else begin
            $display("%0d results never arrived", sb.awaited.size());
            $display("ordered_list_engine_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
